>>> hdl/uct_pkg.sv
// ----------------------------------------------------------------------------
// uct_pkg
// Types and character constants shared by the URL component tagger.
// ----------------------------------------------------------------------------
package uct_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_PROTOCOL = 3'd0,
        PH_SKIP     = 3'd1,
        PH_HOST     = 3'd2,
        PH_PORT     = 3'd3,
        PH_PATH     = 3'd4,
        PH_SEARCH   = 3'd5,
        PH_HASH     = 3'd6
    } t_phase;

    // component tag codes
    localparam logic [2:0] COMP_PROTOCOL = 3'd0;
    localparam logic [2:0] COMP_HOST     = 3'd1;
    localparam logic [2:0] COMP_PORT     = 3'd2;
    localparam logic [2:0] COMP_PATH     = 3'd3;
    localparam logic [2:0] COMP_SEARCH   = 3'd4;
    localparam logic [2:0] COMP_HASH     = 3'd5;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_POUND = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [15:0] PORT_MAX = 16'hFFFF;

    // one result beat
    typedef struct packed {
        logic        char_valid;
        logic [7:0]  char_out;
        logic [2:0]  component;
        logic        end_of_url;
        logic [15:0] port_value;
    } t_tag;

    // what one byte produces in the step logic
    typedef struct packed {
        logic has_res;
        t_tag tag;
    } t_step_res;

endpackage

>>> hdl/uct_if.sv
// ----------------------------------------------------------------------------
// uct_byte_if / uct_tag_if
// Valid/ready channels for the input byte stream and the tagged results.
// ----------------------------------------------------------------------------
interface uct_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface uct_tag_if;
    logic        valid;
    logic        ready;
    logic        char_valid;
    logic [7:0]  char_out;
    logic [2:0]  component;
    logic        end_of_url;
    logic [15:0] port_value;

    modport source (output valid, output char_valid, output char_out, output component,
                    output end_of_url, output port_value, input ready);
    modport sink   (input valid, input char_valid, input char_out, input component,
                    input end_of_url, input port_value, output ready);
endinterface

>>> hdl/uct_step.sv
// ----------------------------------------------------------------------------
// uct_step
// Phase register, port accumulator and the per-byte tagging logic.
// ----------------------------------------------------------------------------
module uct_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [7:0]        i_byte,
    output uct_pkg::t_step_res o_res
);
    import uct_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_accum, n_accum;
    logic        r_stop, n_stop;

    t_phase      p;
    logic        is_digit;
    logic [19:0] prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PROTOCOL;
            r_accum <= '0;
            r_stop  <= 1'b0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_accum <= n_accum;
            r_stop  <= n_stop;
        end
    end

    assign is_digit = i_byte inside {[CH_ZERO:CH_NINE]};
    // accum * 10 + digit
    assign prod = ({4'b0, r_accum} << 3) + ({4'b0, r_accum} << 1)
                + {16'b0, i_byte[3:0]};

    always_comb begin
        n_phase = r_phase;
        n_accum = r_accum;
        n_stop  = r_stop;
        o_res   = '0;
        p       = r_phase;

        if (r_phase == PH_SKIP) begin
            p = PH_HOST;
            n_phase = PH_HOST;
        end

        if (r_phase == PH_SKIP && (i_byte inside {CH_SLASH, CH_COLON})) begin
            n_phase = PH_SKIP;
        end else begin
            case (p)
                PH_HOST: begin
                    if (i_byte == CH_COLON) begin
                        n_phase = PH_PORT;
                        n_accum = '0;
                        n_stop  = 1'b0;
                    end else if (i_byte == CH_SLASH) begin
                        n_phase = PH_PATH;
                    end else if (i_byte != CH_NL) begin
                        o_res.has_res = 1'b1;
                        o_res.tag.char_valid = 1'b1;
                        o_res.tag.char_out = i_byte;
                        o_res.tag.component = COMP_HOST;
                    end
                end
                PH_PORT: begin
                    if (i_byte == CH_SLASH) begin
                        n_phase = PH_PATH;
                    end else if (i_byte == CH_QUEST) begin
                        n_phase = PH_SEARCH;
                    end else if (i_byte == CH_POUND) begin
                        n_phase = PH_HASH;
                    end else if (i_byte != CH_NL) begin
                        if (!r_stop) begin
                            if (is_digit) begin
                                n_accum = (|prod[19:16]) ? PORT_MAX : prod[15:0];
                            end else begin
                                n_stop = 1'b1;
                            end
                        end
                        o_res.has_res = 1'b1;
                        o_res.tag.char_valid = 1'b1;
                        o_res.tag.char_out = i_byte;
                        o_res.tag.component = COMP_PORT;
                    end
                end
                PH_PATH: begin
                    if (i_byte == CH_QUEST) begin
                        n_phase = PH_SEARCH;
                    end else if (i_byte == CH_POUND) begin
                        n_phase = PH_HASH;
                    end else if (i_byte != CH_NL) begin
                        o_res.has_res = 1'b1;
                        o_res.tag.char_valid = 1'b1;
                        o_res.tag.char_out = i_byte;
                        o_res.tag.component = COMP_PATH;
                    end
                end
                PH_SEARCH: begin
                    if (i_byte == CH_POUND) begin
                        n_phase = PH_HASH;
                    end else if (!(i_byte inside {CH_NL, CH_NUL})) begin
                        o_res.has_res = 1'b1;
                        o_res.tag.char_valid = 1'b1;
                        o_res.tag.char_out = i_byte;
                        o_res.tag.component = COMP_SEARCH;
                    end
                end
                PH_HASH: begin
                    if (i_byte != CH_NL) begin
                        o_res.has_res = 1'b1;
                        o_res.tag.char_valid = 1'b1;
                        o_res.tag.char_out = i_byte;
                        o_res.tag.component = COMP_HASH;
                    end
                end
                default: begin
                    // protocol, and any unused phase code
                    n_phase = PH_PROTOCOL;
                    if (i_byte == CH_COLON) begin
                        n_phase = PH_SKIP;
                    end else if (i_byte != CH_NL) begin
                        o_res.has_res = 1'b1;
                        o_res.tag.char_valid = 1'b1;
                        o_res.tag.char_out = i_byte;
                        o_res.tag.component = COMP_PROTOCOL;
                    end
                end
            endcase

            // terminating byte: one end beat carrying the port
            if (i_byte == CH_NL || (p == PH_SEARCH && i_byte == CH_NUL)) begin
                o_res = '0;
                o_res.has_res = 1'b1;
                o_res.tag.end_of_url = 1'b1;
                o_res.tag.port_value = r_accum;
                n_phase = PH_PROTOCOL;
                n_accum = '0;
                n_stop  = 1'b0;
            end
        end
    end

    a_end_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_res.tag.end_of_url) |=> (r_phase == PH_PROTOCOL && r_accum == '0))
        else $error("end of url did not restart the parser");

    a_accum_only_in_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_phase != PH_PORT && !o_res.tag.end_of_url && r_phase != PH_HOST)
        |=> $stable(r_accum))
        else $error("port accumulator changed outside the port phase");

    a_stop_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_stop && r_phase == PH_PORT && !o_res.tag.end_of_url)
        |=> $stable(r_accum))
        else $error("digit accumulated after a non-digit");

endmodule

>>> hdl/uct_out_reg.sv
// ----------------------------------------------------------------------------
// uct_out_reg
// Result register: holds one tagged beat until the sink takes it.
// ----------------------------------------------------------------------------
module uct_out_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  uct_pkg::t_tag i_tag,
    input  logic          i_ready,
    output logic          o_free,
    output logic          o_valid,
    output uct_pkg::t_tag o_tag
);
    import uct_pkg::*;

    logic r_valid;
    t_tag r_tag;

    // slot can take a new beat when empty or being drained this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;

endmodule

>>> hdl/url_component_tagger.sv
// ----------------------------------------------------------------------------
// url_component_tagger
// Splits a URL byte stream into tagged protocol/host/port/path/search/hash.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle, with no gaps of its own, while the result
// register has room or the byte gives no result. A result passes the input
// register, then the result register. The phase register advances once per
// byte. Separator bytes give no result beat; every other byte gives one, and a
// newline (or a NUL inside the search part) gives the end beat with the port.
module url_component_tagger (
    input  logic       i_clk,
    input  logic       i_rst_n,
    uct_byte_if.sink   i_in,
    uct_tag_if.source  o_out
);
    import uct_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       advance;
    logic       out_free;
    logic       out_valid;
    t_step_res  step_res;
    t_tag       out_tag;

    // a byte with no result never waits for the result register
    assign advance    = r_in_valid && (out_free || !step_res.has_res);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
        end
    end

    uct_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_res     (step_res)
    );

    uct_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && step_res.has_res),
        .i_tag   (step_res.tag),
        .i_ready (o_out.ready),
        .o_free  (out_free),
        .o_valid (out_valid),
        .o_tag   (out_tag)
    );

    assign o_out.valid      = out_valid;
    assign o_out.char_valid = out_tag.char_valid;
    assign o_out.char_out   = out_tag.char_out;
    assign o_out.component  = out_tag.component;
    assign o_out.end_of_url = out_tag.end_of_url;
    assign o_out.port_value = out_tag.port_value;

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_tag.char_valid != out_tag.end_of_url))
        else $error("result beat is neither a character nor an end");

endmodule
